>>> src/cfs_pkg.sv
// cfs_pkg: shared types and face codes for the cube-map face select block
// no dependencies; used by every module under src

package cfs_pkg;

  // face codes on the result channel
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // sideband that travels with each item through the divider chain
  typedef struct packed {
    logic       valid;
    logic [2:0] face;
    logic       degen;
  } side_t;

endpackage

>>> src/cubemap_face_select_core.sv
// cubemap_face_select_core: an item passes from input transfer to result through
// the select stage, one divider cell per coordinate bit and the output register
// throughput one item per cycle through the chain of division cells, while the output skid entry is empty
// reset (synchronous, rst_n low) empties the chain and the output skid stage
// depends on cfs_pkg, cfs_front, cfs_cell, cfs_out_skid

module cubemap_face_select_core #(
  parameter int  COMP_BITS   = 16,
  parameter int  COORD_BITS  = 16,
  localparam int IN_TDATA_W  = ((3*COMP_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((3 + 2*COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // dir_x, dir_y, dir_z from the lowest bit up
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // face_index, u_coord, v_coord from the lowest bit up
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // degenerate
  output logic                   out_tuser
);

  cfs_pkg::side_t        side   [COORD_BITS+1];
  logic [COMP_BITS-1:0]  m_s    [COORD_BITS+1];
  logic [COMP_BITS:0]    ru_s   [COORD_BITS+1];
  logic [COMP_BITS:0]    rv_s   [COORD_BITS+1];
  logic [COORD_BITS-1:0] qu_s   [COORD_BITS+1];
  logic [COORD_BITS-1:0] qv_s   [COORD_BITS+1];
  logic                  pipe_en;
  logic [2:0]            face;
  logic [COORD_BITS-1:0] u_coord, v_coord;

  assign in_tready = pipe_en;

  // major axis and biased minor components
  cfs_front #(.COMP_BITS(COMP_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (in_tvalid),
    .dir_x    (in_tdata[COMP_BITS-1:0]),
    .dir_y    (in_tdata[2*COMP_BITS-1:COMP_BITS]),
    .dir_z    (in_tdata[3*COMP_BITS-1:2*COMP_BITS]),
    .side_r   (side[0]),
    .m_r      (m_s[0]),
    .su_r     (ru_s[0]),
    .sv_r     (rv_s[0])
  );

  assign qu_s[0] = '0;
  assign qv_s[0] = '0;

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < COORD_BITS; i++) begin : g_cell
    cfs_cell #(.COMP_BITS(COMP_BITS), .COORD_BITS(COORD_BITS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .side_in (side[i]),
      .m_in    (m_s[i]),
      .ru_in   (ru_s[i]),
      .rv_in   (rv_s[i]),
      .qu_in   (qu_s[i]),
      .qv_in   (qv_s[i]),
      .side_r  (side[i+1]),
      .m_r     (m_s[i+1]),
      .ru_r    (ru_s[i+1]),
      .rv_r    (rv_s[i+1]),
      .qu_r    (qu_s[i+1]),
      .qv_r    (qv_s[i+1])
    );
  end

  // result register and skid entry
  cfs_out_skid #(.COORD_BITS(COORD_BITS)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .side_in   (side[COORD_BITS]),
    .qu_in     (qu_s[COORD_BITS]),
    .qv_in     (qv_s[COORD_BITS]),
    .pipe_en   (pipe_en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .face      (face),
    .u_coord   (u_coord),
    .v_coord   (v_coord),
    .degen     (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({v_coord, u_coord, face});

endmodule

>>> src/cfs_front.sv
// cfs_front: major-axis select stage, picks face, major magnitude and the
// two biased minor components (c + m); depends on cfs_pkg

module cfs_front #(
  parameter int COMP_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [COMP_BITS-1:0] dir_x,
  input  logic [COMP_BITS-1:0] dir_y,
  input  logic [COMP_BITS-1:0] dir_z,
  output cfs_pkg::side_t       side_r,
  output logic [COMP_BITS-1:0] m_r,
  output logic [COMP_BITS:0]   su_r,
  output logic [COMP_BITS:0]   sv_r
);

  logic signed [COMP_BITS:0]   xs, ys, zs;
  logic signed [COMP_BITS:0]   xn, yn, zn;
  logic [COMP_BITS-1:0]        ax, ay, az;
  logic [COMP_BITS-1:0]        m_nxt;
  logic signed [COMP_BITS:0]   cu, cv;
  logic signed [COMP_BITS+1:0] su_full, sv_full;
  logic [2:0]                  face_nxt;
  logic                        degen_nxt;

  // sign extend and take magnitudes at full precision
  always_comb begin
    xs = {dir_x[COMP_BITS-1], dir_x};
    ys = {dir_y[COMP_BITS-1], dir_y};
    zs = {dir_z[COMP_BITS-1], dir_z};
    xn = -xs;
    yn = -ys;
    zn = -zs;
    ax = xs[COMP_BITS] ? xn[COMP_BITS-1:0] : xs[COMP_BITS-1:0];
    ay = ys[COMP_BITS] ? yn[COMP_BITS-1:0] : ys[COMP_BITS-1:0];
    az = zs[COMP_BITS] ? zn[COMP_BITS-1:0] : zs[COMP_BITS-1:0];
  end

  // strict compares: ties go to the later axis, z before y before x
  always_comb begin
    degen_nxt = (ax == '0) && (ay == '0) && (az == '0);
    if ((ax > ay) && (ax > az)) begin
      m_nxt = ax;
      cv    = ys;
      if (!xs[COMP_BITS]) begin
        face_nxt = cfs_pkg::FACE_POS_X;
        cu       = zs;
      end else begin
        face_nxt = cfs_pkg::FACE_NEG_X;
        cu       = zn;
      end
    end else if (ay > az) begin
      m_nxt = ay;
      cu    = xs;
      if (!ys[COMP_BITS]) begin
        face_nxt = cfs_pkg::FACE_POS_Y;
        cv       = zs;
      end else begin
        face_nxt = cfs_pkg::FACE_NEG_Y;
        cv       = zn;
      end
    end else begin
      m_nxt = az;
      cv    = ys;
      if (!zs[COMP_BITS] && (zs != '0)) begin
        face_nxt = cfs_pkg::FACE_POS_Z;
        cu       = xn;
      end else begin
        face_nxt = cfs_pkg::FACE_NEG_Z;
        cu       = xs;
      end
    end
  end

  // bias into [0, 2m]
  always_comb begin
    su_full = {cu[COMP_BITS], cu} + $signed({2'b00, m_nxt});
    sv_full = {cv[COMP_BITS], cv} + $signed({2'b00, m_nxt});
  end

  // valid bit is reset, payload is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r.valid <= in_valid;
    end
    if (en) begin
      side_r.face  <= face_nxt;
      side_r.degen <= degen_nxt;
      m_r          <= m_nxt;
      su_r         <= su_full[COMP_BITS:0];
      sv_r         <= sv_full[COMP_BITS:0];
    end
  end

endmodule

>>> src/cfs_cell.sv
// cfs_cell: one restoring-division cell, yields one quotient bit for u and v
// and hands the shifted remainders on; depends on cfs_pkg

module cfs_cell #(
  parameter int COMP_BITS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cfs_pkg::side_t        side_in,
  input  logic [COMP_BITS-1:0]  m_in,
  input  logic [COMP_BITS:0]    ru_in,
  input  logic [COMP_BITS:0]    rv_in,
  input  logic [COORD_BITS-1:0] qu_in,
  input  logic [COORD_BITS-1:0] qv_in,
  output cfs_pkg::side_t        side_r,
  output logic [COMP_BITS-1:0]  m_r,
  output logic [COMP_BITS:0]    ru_r,
  output logic [COMP_BITS:0]    rv_r,
  output logic [COORD_BITS-1:0] qu_r,
  output logic [COORD_BITS-1:0] qv_r
);

  logic [COMP_BITS:0] m_ext;
  logic               bit_u, bit_v;
  logic [COMP_BITS:0] du, dv;

  // trial subtract of the major magnitude
  always_comb begin
    m_ext = {1'b0, m_in};
    bit_u = (ru_in >= m_ext);
    bit_v = (rv_in >= m_ext);
    du    = bit_u ? (ru_in - m_ext) : ru_in;
    dv    = bit_v ? (rv_in - m_ext) : rv_in;
  end

  // valid bit is reset; remainder stays at most m, so doubling fits the extra bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r.valid <= side_in.valid;
    end
    if (en) begin
      side_r.face  <= side_in.face;
      side_r.degen <= side_in.degen;
      m_r          <= m_in;
      ru_r         <= {du[COMP_BITS-1:0], 1'b0};
      rv_r         <= {dv[COMP_BITS-1:0], 1'b0};
      qu_r         <= {qu_in[COORD_BITS-2:0], bit_u};
      qv_r         <= {qv_in[COORD_BITS-2:0], bit_v};
    end
  end

endmodule

>>> src/cfs_out_skid.sv
// cfs_out_skid: output register plus one skid entry, decouples the result
// channel from the divider chain; depends on cfs_pkg

module cfs_out_skid #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfs_pkg::side_t        side_in,
  input  logic [COORD_BITS-1:0] qu_in,
  input  logic [COORD_BITS-1:0] qv_in,
  output logic                  pipe_en,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            face,
  output logic [COORD_BITS-1:0] u_coord,
  output logic [COORD_BITS-1:0] v_coord,
  output logic                  degen
);

  localparam int PW = 3 + 2*COORD_BITS + 1;

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic [PW-1:0] out_data_r, out_data_nxt;
  logic [PW-1:0] skid_data_r, skid_data_nxt;
  logic [PW-1:0] in_data;
  logic          take;

  // zero vector forces zero coordinates
  always_comb begin
    if (side_in.degen) begin
      in_data = {side_in.face, {(2*COORD_BITS){1'b0}}, 1'b1};
    end else begin
      in_data = {side_in.face, qv_in, qu_in, 1'b0};
    end
  end

  assign pipe_en = !skid_valid_r;
  assign take    = side_in.valid && pipe_en;

  // output register is loaded from skid first, otherwise from the chain
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = take;
        out_data_nxt  = in_data;
      end
    end else if (take) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign degen     = out_data_r[0];
  assign u_coord   = out_data_r[COORD_BITS:1];
  assign v_coord   = out_data_r[2*COORD_BITS:COORD_BITS+1];
  assign face      = out_data_r[PW-1:2*COORD_BITS+1];

endmodule
